// ===== rtl/cdd_pkg.sv =====
// ----------------------------------------------------------------------------
// cdd_pkg
// shared widths, constants, month tables and types of the date difference block
// ----------------------------------------------------------------------------
package cdd_pkg;

  localparam int DayW    = 5;
  localparam int MonthW  = 4;
  localparam int YearW   = 14;
  localparam int DaysW   = 22;
  localparam int DayNumW = 23;
  localparam int OrderW  = 2;
  localparam int KeyW    = YearW + MonthW + DayW;

  localparam int DaysPerYear = 365;
  // floor(x / 100) == (x * Recip100) >> RecipShift for every x below 2^15
  localparam int Recip100    = 5243;
  localparam int RecipW      = 13;
  localparam int RecipShift  = 19;
  localparam int ProdW       = YearW + RecipW;
  localparam int CenturyW    = ProdW - RecipShift;

  localparam logic [DaysW-1:0] DaysMax = {DaysW{1'b1}};

  typedef enum logic [OrderW-1:0] {
    ORDER_EQUAL         = 2'd0,
    ORDER_FIRST_LATER   = 2'd1,
    ORDER_FIRST_EARLIER = 2'd2
  } order_e;

  // per-date result of the day number unit
  typedef struct packed {
    logic               valid;
    logic [DayNumW-1:0] num;
  } day_info_t;

  // days in a month of a common year, 0 for codes that are no month
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of a month in a common year
  function automatic logic [8:0] month_start(input logic [MonthW-1:0] m);
    logic [8:0] start;
    case (m)
      4'd2:    start = 9'd31;
      4'd3:    start = 9'd59;
      4'd4:    start = 9'd90;
      4'd5:    start = 9'd120;
      4'd6:    start = 9'd151;
      4'd7:    start = 9'd181;
      4'd8:    start = 9'd212;
      4'd9:    start = 9'd243;
      4'd10:   start = 9'd273;
      4'd11:   start = 9'd304;
      4'd12:   start = 9'd334;
      default: start = 9'd0;
    endcase
    return start;
  endfunction

endpackage

// ===== rtl/cdd_day_number.sv =====
// ----------------------------------------------------------------------------
// cdd_day_number
// day number since 0000-01-01 and validity check of one gregorian date
// ----------------------------------------------------------------------------
module cdd_day_number import cdd_pkg::*; (
  input  logic [DayW-1:0]   day_i,
  input  logic [MonthW-1:0] month_i,
  input  logic [YearW-1:0]  year_i,
  output day_info_t         info_o
);

  logic [ProdW-1:0]    prod;
  logic [CenturyW-1:0] century;
  logic [6:0]          rem100;
  logic                leap;
  logic [12:0]         ceil4;
  logic [CenturyW-1:0] ceil100;
  logic [6:0]          ceil400;
  logic [DayNumW-1:0]  year_days;
  logic [DayW-1:0]     len;
  logic                month_ok;

  // year / 100 by reciprocal multiply
  assign prod    = {{RecipW{1'b0}}, year_i} * ProdW'(Recip100);
  assign century = prod[ProdW-1:RecipShift];
  assign rem100  = 7'(year_i - YearW'({{(YearW-CenturyW){1'b0}}, century} * YearW'(100)));

  // centuries are leap only when the century count is a multiple of four
  assign leap = (rem100 == 7'd0) ? (century[1:0] == 2'd0) : (year_i[1:0] == 2'd0);

  // leap days in all years before this one
  assign ceil4   = 13'(({1'b0, year_i} + 15'd3) >> 2);
  assign ceil100 = century + CenturyW'(rem100 != 7'd0);
  assign ceil400 = 7'(({1'b0, ceil100} + 9'd3) >> 2);

  assign year_days = DayNumW'({{(DayNumW-YearW){1'b0}}, year_i} * DayNumW'(DaysPerYear));

  assign info_o.num = year_days
                    + DayNumW'(ceil4)
                    - DayNumW'(ceil100)
                    + DayNumW'(ceil400)
                    + DayNumW'(month_start(month_i))
                    + DayNumW'((month_i > 4'd2) && leap)
                    + DayNumW'(day_i)
                    - DayNumW'(1);

  // length of the month, february stretched in leap years
  always_comb begin
    len = month_len(month_i);
    if (month_i == 4'd2 && leap) begin
      len = 5'd29;
    end
  end

  assign month_ok    = month_i inside {[4'd1:4'd12]};
  assign info_o.valid = month_ok && (day_i != '0) && (day_i <= len);

endmodule

// ===== rtl/calendar_date_difference.sv =====
// ----------------------------------------------------------------------------
// calendar_date_difference
// absolute day count between two gregorian dates, their order and validity
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in       input      in_valid_i/in_ready_o  first_day/month/year, second_day/month/year
//  out      output     out_valid_o/out_ready_i days_between, order, first/second_valid
//
//  two register stages: day numbers are formed from the ports into the stage
//  register, the difference and saturation go into the output register
//  one item per cycle while the output is taken, a result passes the stage register
//  and then the output register; while a result waits at the output the stage register
//  takes one more item, then the input stalls until the output is taken
//  reset clears both valid bits only; payload registers are not reset
//
module calendar_date_difference import cdd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [DayW-1:0]   first_day_i,
  input  logic [MonthW-1:0] first_month_i,
  input  logic [YearW-1:0]  first_year_i,
  input  logic [DayW-1:0]   second_day_i,
  input  logic [MonthW-1:0] second_month_i,
  input  logic [YearW-1:0]  second_year_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [DaysW-1:0]  days_between_o,
  output logic [OrderW-1:0] order_o,
  output logic              first_valid_o,
  output logic              second_valid_o
);

  // per-date day numbers and validity
  day_info_t first_info, second_info;

  cdd_day_number u_first (
    .day_i   (first_day_i),
    .month_i (first_month_i),
    .year_i  (first_year_i),
    .info_o  (first_info)
  );

  cdd_day_number u_second (
    .day_i   (second_day_i),
    .month_i (second_month_i),
    .year_i  (second_year_i),
    .info_o  (second_info)
  );

  // order from the raw fields, year then month then day
  logic [KeyW-1:0] first_key, second_key;
  order_e          order_d;

  assign first_key  = {first_year_i, first_month_i, first_day_i};
  assign second_key = {second_year_i, second_month_i, second_day_i};

  always_comb begin
    if (first_key > second_key) begin
      order_d = ORDER_FIRST_LATER;
    end else if (first_key < second_key) begin
      order_d = ORDER_FIRST_EARLIER;
    end else begin
      order_d = ORDER_EQUAL;
    end
  end

  // handshake: each stage loads when empty or when it hands on
  logic s1_valid_q, out_valid_q;
  logic out_load, s1_load;

  assign out_load   = !out_valid_q || out_ready_i;
  assign s1_load    = !s1_valid_q || out_load;
  assign in_ready_o = s1_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // stage register: day numbers, validity, order
  day_info_t s1_first_q, s1_second_q;
  order_e    s1_order_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_load) begin
      s1_first_q  <= first_info;
      s1_second_q <= second_info;
      s1_order_q  <= order_d;
    end
  end

  // absolute difference, saturated, zero when either date is bad
  logic [DayNumW-1:0] diff;
  logic [DaysW-1:0]   days_d;

  always_comb begin
    if (s1_first_q.num >= s1_second_q.num) begin
      diff = s1_first_q.num - s1_second_q.num;
    end else begin
      diff = s1_second_q.num - s1_first_q.num;
    end
    if (!(s1_first_q.valid && s1_second_q.valid)) begin
      days_d = '0;
    end else if (diff[DayNumW-1]) begin
      days_d = DaysMax;
    end else begin
      days_d = diff[DaysW-1:0];
    end
  end

  // output register
  logic [DaysW-1:0] days_q;
  order_e           order_q;
  logic             first_valid_q, second_valid_q;

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && out_load) begin
      days_q         <= days_d;
      order_q        <= s1_order_q;
      first_valid_q  <= s1_first_q.valid;
      second_valid_q <= s1_second_q.valid;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign days_between_o = days_q;
  assign order_o        = OrderW'(order_q);
  assign first_valid_o  = first_valid_q;
  assign second_valid_o = second_valid_q;

endmodule
